/* hw/rtl/biosignal_frame_deframer_assert.svh */
// ----------------------------------------------------------------------------
// Biosignal frame deframer assertion macros
// Shared macros for the concurrent checks on the deframer ports.
// ----------------------------------------------------------------------------
`ifndef BIOSIGNAL_FRAME_DEFRAMER_ASSERT_SVH
`define BIOSIGNAL_FRAME_DEFRAMER_ASSERT_SVH

// Implication that must hold in the same cycle.
`define BFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Implication that must hold in the following cycle.
`define BFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

/* hw/rtl/bfd_pkg.sv */
// ----------------------------------------------------------------------------
// Deframer package
// Constants, types and small helper functions shared by the deframer files.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam int FRAME_CAPACITY   = 64;
  localparam int CHANNELS         = 8;
  localparam int MOTION_FRAME_LEN = 57;
  localparam int SHORT_LEN_A      = 21;
  localparam int SHORT_LEN_B      = 22;
  localparam int IMU_WORDS        = 9;

  localparam int ADDR_W = $clog2(FRAME_CAPACITY);
  localparam int FILL_W = $clog2(FRAME_CAPACITY + 1);
  localparam int LEN_W  = 6;
  localparam int ITEM_W = 5;

  localparam int SEQ_POS     = 1;
  localparam int LOFF_P_POS  = 18;
  localparam int LOFF_N_POS  = 19;
  localparam int EEG_BASE    = 2;
  localparam int IMU_BASE    = 20;

  // Scale: raw * 4e6 * 256 / (32767 * 79.57 * gain), exact integer form.
  localparam int NUM_W = 54;
  localparam int DEN_W = 37;
  localparam int QUO_W = 24;
  localparam int DSH_W = DEN_W + QUO_W - 1;
  localparam logic [36:0] SCALE_NUM = 37'd102400000000;
  localparam logic [28:0] SCALE_DEN = 29'd260727019;
  localparam logic [7:0]  DEFAULT_GAIN = 8'd12;

  localparam logic [7:0]  START_RST = 8'hA0;
  localparam logic [7:0]  END_RST   = 8'hC0;
  localparam logic [63:0] GAIN_RST  = 64'h0C0C_0C0C_0C0C_0C0C;

  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_END   = 2'd1,
    CFG_GAIN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_EEG   = 2'd0,
    KIND_ACCEL = 2'd1,
    KIND_GYRO  = 2'd2,
    KIND_MAG   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } emit_state_t;

  typedef struct packed {
    logic        go;
    logic        err;
    logic        motion;
    logic [7:0]  seq;
    logic [7:0]  loff_p;
    logic [7:0]  loff_n;
    logic [31:0] resync;
  } bfd_job_t;

  function automatic kind_t imu_kind(input logic [3:0] k);
    kind_t r;
    if (k < 4'd3) begin
      r = KIND_ACCEL;
    end else if (k < 4'd6) begin
      r = KIND_GYRO;
    end else begin
      r = KIND_MAG;
    end
    return r;
  endfunction

  function automatic logic [2:0] imu_axis(input logic [3:0] k);
    logic [3:0] a;
    if (k < 4'd3) begin
      a = k;
    end else if (k < 4'd6) begin
      a = k - 4'd3;
    end else begin
      a = k - 4'd6;
    end
    return a[2:0];
  endfunction

endpackage

/* hw/rtl/bfd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module bfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/bfd_ingest.sv */
// ----------------------------------------------------------------------------
// Deframer byte intake
// Writes received bytes into the frame store and decides frame boundaries.
// ----------------------------------------------------------------------------
module bfd_ingest
  import bfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data,
  input  logic [7:0]        start_byte,
  input  logic [7:0]        end_byte,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output bfd_job_t          job
);

  logic [FILL_W-1:0] fill_r, fill_nxt, fill_inc;
  logic              locked_r, locked_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [7:0]        byte0_r, byte0_nxt;
  logic [7:0]        seq_r, seq_nxt;
  logic [7:0]        loffp_r, loffp_nxt;
  logic [7:0]        loffn_r, loffn_nxt;
  logic [31:0]       resync_r, resync_nxt;
  logic              head_ok, restart, bump;

  assign fill_inc = fill_r + FILL_W'(1);
  assign head_ok  = (byte0_r == start_byte) && (data == end_byte);

  always_comb begin
    fill_nxt   = fill_r;
    locked_nxt = locked_r;
    len_nxt    = len_r;
    byte0_nxt  = byte0_r;
    seq_nxt    = seq_r;
    loffp_nxt  = loffp_r;
    loffn_nxt  = loffn_r;
    wr_en      = 1'b0;
    wr_addr    = fill_r[ADDR_W-1:0];
    wr_data    = data;
    restart    = 1'b0;
    bump       = 1'b0;
    job        = '0;
    if (accept) begin
      if (fill_r == '0) begin
        restart = 1'b1;
      end else if (fill_r < FILL_W'(FRAME_CAPACITY)) begin
        wr_en    = 1'b1;
        fill_nxt = fill_inc;
        if (locked_r && (len_r != '0)) begin
          if (fill_inc == FILL_W'(len_r)) begin
            job.go = 1'b1;
            if (head_ok) begin
              fill_nxt = '0;
            end else begin
              locked_nxt = 1'b0;
              bump       = 1'b1;
              restart    = 1'b1;
              job.err    = 1'b1;
            end
          end
        end else if (((fill_inc == FILL_W'(SHORT_LEN_A)) ||
                      (fill_inc == FILL_W'(SHORT_LEN_B)) ||
                      (fill_inc == FILL_W'(MOTION_FRAME_LEN))) && head_ok) begin
          locked_nxt = 1'b1;
          len_nxt    = LEN_W'(fill_inc);
          fill_nxt   = '0;
          job.go     = 1'b1;
        end else if (fill_inc >= FILL_W'(FRAME_CAPACITY)) begin
          fill_nxt = '0;
          bump     = 1'b1;
          job.go   = 1'b1;
          job.err  = 1'b1;
        end
      end else begin
        bump    = 1'b1;
        restart = 1'b1;
        job.go  = 1'b1;
        job.err = 1'b1;
      end
      if (wr_en && (wr_addr == ADDR_W'(SEQ_POS))) begin
        seq_nxt = data;
      end
      if (wr_en && (wr_addr == ADDR_W'(LOFF_P_POS))) begin
        loffp_nxt = data;
      end
      if (wr_en && (wr_addr == ADDR_W'(LOFF_N_POS))) begin
        loffn_nxt = data;
      end
      // A restart that sees the start byte overrides the discarded byte's write with the new opener.
      if (restart) begin
        fill_nxt = '0;
        if (data == start_byte) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          fill_nxt  = FILL_W'(1);
          byte0_nxt = data;
        end
      end
    end
    resync_nxt = (bump && (resync_r != '1)) ? resync_r + 32'd1 : resync_r;
    job.motion = (fill_inc == FILL_W'(MOTION_FRAME_LEN));
    job.seq    = seq_r;
    job.loff_p = loffp_r;
    job.loff_n = loffn_r;
    job.resync = resync_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      locked_r <= 1'b0;
      len_r    <= '0;
      resync_r <= '0;
    end else begin
      fill_r   <= fill_nxt;
      locked_r <= locked_nxt;
      len_r    <= len_nxt;
      resync_r <= resync_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte0_r <= byte0_nxt;
    seq_r   <= seq_nxt;
    loffp_r <= loffp_nxt;
    loffn_r <= loffn_nxt;
  end

endmodule

/* hw/rtl/bfd_emit.sv */
// ----------------------------------------------------------------------------
// Deframer result sequencer
// Reads a finished frame from the store, scales EEG samples with a
// bit-serial divider and drives the result register.
// ----------------------------------------------------------------------------
module bfd_emit
  import bfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  bfd_job_t           job,
  input  logic [63:0]        gain_table,
  output logic               busy,
  output logic               rd_en,
  output logic [ADDR_W-1:0]  rd_addr,
  input  logic [7:0]         rd_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic [1:0]         out_kind,
  output logic [2:0]         out_element_index,
  output logic signed [24:0] out_eeg_value,
  output logic [31:0]        out_imu_word,
  output logic [7:0]         out_sequence_res,
  output logic [7:0]         out_lead_off_pos,
  output logic [7:0]         out_lead_off_neg,
  output logic               out_has_motion,
  output logic [31:0]        out_resync_total,
  output logic               out_last
);

  emit_state_t        state_r, state_nxt;
  logic [ITEM_W-1:0]  item_r;
  logic [2:0]         byte_r;
  logic               err_r, motion_r, neg_r;
  logic [7:0]         seq_r, loffp_r, loffn_r;
  logic [31:0]        resync_r, acc_r;
  logic [NUM_W-1:0]   rem_r;
  logic [DSH_W-1:0]   dsh_r;
  logic [QUO_W-1:0]   quo_r;
  logic [4:0]         step_r;
  logic               is_eeg, last_item, load, ge, div_done;
  logic [2:0]         nbytes;
  logic [ITEM_W-1:0]  imu_k;
  logic [ADDR_W-1:0]  base;
  logic [1:0]         cap_idx;
  logic [15:0]        raw;
  logic [16:0]        mag;
  logic [7:0]         gain;
  logic               out_valid_r;

  assign is_eeg    = item_r < ITEM_W'(CHANNELS);
  assign imu_k     = item_r - ITEM_W'(CHANNELS);
  assign nbytes    = is_eeg ? 3'd2 : 3'd4;
  assign last_item = motion_r ? (item_r == ITEM_W'(CHANNELS + IMU_WORDS - 1))
                              : (item_r == ITEM_W'(CHANNELS - 1));
  assign base      = is_eeg ? ADDR_W'(EEG_BASE) + ADDR_W'({item_r, 1'b0})
                            : ADDR_W'(IMU_BASE) + ADDR_W'({imu_k, 2'b00});
  assign cap_idx   = 2'(byte_r - 3'd1);
  assign raw       = {acc_r[7:0], acc_r[15:8]};
  assign mag       = raw[15] ? 17'h10000 - {1'b0, raw} : {1'b0, raw};
  assign gain      = (gain_table[{item_r[2:0], 3'b000} +: 8] == 8'd0)
                     ? DEFAULT_GAIN : gain_table[{item_r[2:0], 3'b000} +: 8];
  assign ge        = DSH_W'(rem_r) >= dsh_r;
  assign div_done  = step_r == 5'(QUO_W - 1);
  assign load      = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (job.go) state_nxt = job.err ? ST_OUT : ST_FETCH;
      ST_FETCH: if (byte_r == nbytes) state_nxt = is_eeg ? ST_MUL : ST_OUT;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_OUT;
      ST_OUT:   if (load) state_nxt = (err_r || last_item) ? ST_IDLE : ST_FETCH;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en   = (state_r == ST_FETCH) && (byte_r < nbytes);
    rd_addr = base + ADDR_W'(byte_r[1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        item_r   <= '0;
        byte_r   <= '0;
        err_r    <= job.err;
        motion_r <= job.motion;
        seq_r    <= job.seq;
        loffp_r  <= job.loff_p;
        loffn_r  <= job.loff_n;
        resync_r <= job.resync;
      end
      ST_FETCH: begin
        if (byte_r != 3'd0) begin
          acc_r[{cap_idx, 3'b000} +: 8] <= rd_data;
        end
        byte_r <= (byte_r == nbytes) ? 3'd0 : byte_r + 3'd1;
      end
      ST_MUL: begin
        neg_r  <= raw[15];
        rem_r  <= NUM_W'(mag) * NUM_W'(SCALE_NUM);
        dsh_r  <= DSH_W'(DEN_W'(SCALE_DEN) * DEN_W'(gain)) << (QUO_W - 1);
        quo_r  <= '0;
        step_r <= '0;
      end
      ST_DIV: begin
        if (ge) begin
          rem_r <= NUM_W'(DSH_W'(rem_r) - dsh_r);
        end
        quo_r  <= {quo_r[QUO_W-2:0], ge};
        dsh_r  <= dsh_r >> 1;
        step_r <= step_r + 5'd1;
      end
      ST_OUT: begin
        if (load) begin
          item_r <= item_r + ITEM_W'(1);
        end
      end
      default: begin
        byte_r <= '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status        <= err_r;
      out_last          <= err_r || last_item;
      out_resync_total  <= resync_r;
      out_kind          <= KIND_EEG;
      out_element_index <= '0;
      out_eeg_value     <= '0;
      out_imu_word      <= '0;
      out_sequence_res  <= '0;
      out_lead_off_pos  <= '0;
      out_lead_off_neg  <= '0;
      out_has_motion    <= 1'b0;
      if (!err_r) begin
        out_sequence_res <= seq_r;
        out_lead_off_pos <= loffp_r;
        out_lead_off_neg <= loffn_r;
        out_has_motion   <= motion_r;
        if (is_eeg) begin
          out_element_index <= item_r[2:0];
          out_eeg_value     <= neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
        end else begin
          out_kind          <= imu_kind(imu_k[3:0]);
          out_element_index <= imu_axis(imu_k[3:0]);
          out_imu_word      <= acc_r;
        end
      end
    end
  end

endmodule

/* hw/rtl/biosignal_frame_deframer.sv */
// ----------------------------------------------------------------------------
// Biosignal frame deframer
// Start/end byte deframer with length lock, EEG scaling and IMU word output.
// ----------------------------------------------------------------------------
// A byte that completes a frame starts the sequencer. Each EEG item is
// fetched with two store reads, multiplied, divided bit-serially and then
// output; each IMU item is fetched with four store reads and then output.
// A resync status item goes straight from idle to the output state.
// Throughput: one byte per cycle while a frame is being gathered; a closing
// byte holds the input until the last result of its frame has been loaded
// into the result register, so result stalls hold it too. Reset: synchronous,
// active low; the frame store is not cleared.
module biosignal_frame_deframer
  import bfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic [1:0]         out_kind,
  output logic [2:0]         out_element_index,
  output logic signed [24:0] out_eeg_value,
  output logic [31:0]        out_imu_word,
  output logic [7:0]         out_sequence_res,
  output logic [7:0]         out_lead_off_pos,
  output logic [7:0]         out_lead_off_neg,
  output logic               out_has_motion,
  output logic [31:0]        out_resync_total,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [7:0]        start_r, end_r;
  logic [63:0]       gain_r;
  logic              busy, wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;
  bfd_job_t          job;

  // Configuration writes always complete; an unknown index is dropped.
  assign cfg_ready = 1'b1;

  // The intake takes a byte only while the sequencer has no frame in hand,
  // so the store is never written and read for the same frame at once.
  assign in_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RST;
      end_r   <= END_RST;
      gain_r  <= GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START: start_r <= cfg_data[7:0];
        CFG_END:   end_r   <= cfg_data[7:0];
        CFG_GAIN:  gain_r  <= cfg_data;
        default:   start_r <= start_r;
      endcase
    end
  end

  bfd_ingest u_ingest (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_valid && in_ready),
    .data       (in_data_byte),
    .start_byte (start_r),
    .end_byte   (end_r),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .job        (job)
  );

  // The frame store: one byte per entry, filled by the intake and read back
  // by the sequencer.
  bfd_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  bfd_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .job               (job),
    .gain_table        (gain_r),
    .busy              (busy),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_kind          (out_kind),
    .out_element_index (out_element_index),
    .out_eeg_value     (out_eeg_value),
    .out_imu_word      (out_imu_word),
    .out_sequence_res  (out_sequence_res),
    .out_lead_off_pos  (out_lead_off_pos),
    .out_lead_off_neg  (out_lead_off_neg),
    .out_has_motion    (out_has_motion),
    .out_resync_total  (out_resync_total),
    .out_last          (out_last)
  );

endmodule

/* hw/rtl/bfd_checker.sv */
// ----------------------------------------------------------------------------
// Deframer port checker
// Concurrent checks on the deframer ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "biosignal_frame_deframer_assert.svh"

module bfd_checker
  import bfd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         in_data_byte,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_status,
  input logic [1:0]         out_kind,
  input logic [2:0]         out_element_index,
  input logic signed [24:0] out_eeg_value,
  input logic [31:0]        out_imu_word,
  input logic [7:0]         out_sequence_res,
  input logic [7:0]         out_lead_off_pos,
  input logic [7:0]         out_lead_off_neg,
  input logic               out_has_motion,
  input logic [31:0]        out_resync_total,
  input logic               out_last,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [1:0]         cfg_index,
  input logic [63:0]        cfg_data
);

  // A stalled result keeps its payload.
  `BFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_imu_word) && $stable(out_eeg_value))

  // A resync status transfer is always the only result of its byte.
  `BFD_ASSERT_NOW(a_err_last, clk, rst_n, out_valid && out_status, out_last && out_eeg_value == 0 && out_imu_word == 0)

  // IMU words only come from motion frames.
  `BFD_ASSERT_NOW(a_imu_motion, clk, rst_n, out_valid && !out_status && out_kind != KIND_EEG, out_has_motion && out_eeg_value == 0)

  // The error count never goes backwards between transfers.
  `BFD_ASSERT_NEXT(a_cnt_mono, clk, rst_n, out_valid && out_ready, !out_valid || out_resync_total >= $past(out_resync_total))

endmodule

bind biosignal_frame_deframer bfd_checker u_bfd_checker (.*);
